// File: sv/rmn_pkg.sv
// rmn_pkg: shared types, constants and sequencer codes of the ring modulator
// used by every module of the block; depends on nothing else
`default_nettype none

package rmn_pkg;

  // defaults for the top level parameters
  localparam int TRACKS_DEF    = 8;
  localparam int SINE_BITS_DEF = 10;

  // phase accumulators start at a quarter turn
  localparam logic [31:0] PHASE_RESET = 32'h4000_0000;

  // q15 unity and sine polynomial coefficients
  localparam logic [16:0] Q15_ONE = 17'd32768;
  localparam logic [16:0] COEF_A  = 17'd51472;
  localparam logic [16:0] COEF_B  = 17'd21024;
  localparam logic [16:0] COEF_C  = 17'd2320;

  // output saturation limit
  localparam logic signed [63:0] SAMPLE_MAX = 64'sd8388607;

  // configuration register index
  localparam logic [1:0] REG_MOD_GAIN = 2'd0;

  // input transaction
  typedef struct packed {
    logic [2:0]         track;
    logic signed [23:0] sample;
    logic signed [31:0] phase_step;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [2:0]         out_track;
    logic signed [23:0] out_sample;
  } out_t;

  // request to the shared multiplier
  typedef struct packed {
    logic               en;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_NEXT = 3'b100
  } state_e;

  // multiplier passes of one transaction
  typedef enum logic [2:0] {
    STEP_SQ  = 3'd0,  // u * u
    STEP_C   = 3'd1,  // c * u^2
    STEP_IN  = 3'd2,  // inner * u^2
    STEP_MID = 3'd3,  // mid * u
    STEP_GS  = 3'd4,  // gain * sine
    STEP_SF  = 3'd5   // sample * factor
  } step_e;

endpackage

`default_nettype wire

// File: sv/ring_modulator_nco.sv
// ring_modulator_nco: top level, sequencer, phase accumulators and datapath
// instantiates rmn_apb and rmn_mul, uses rmn_pkg
//
// Usage: each input transaction carries a track, a signed 24-bit sample and
// a signed phase step. The block returns one output transaction with the
// track echoed and sample * ((1 - g) + g * sin(phase)), rounded to nearest,
// where phase is the track's accumulator before the step; the accumulator
// then advances by the step. Tracks at or beyond TRACKS pass the sample
// unchanged and touch no accumulator.
// The sequencer runs six passes through one shared 32x32 multiplier after
// the accept cycle, each a multiply state and then a state that takes the
// product and loads the next operands; in_stall_o is high for that whole
// time, so a new transaction is accepted only once the last pass is done.
// The result sits in an output register, so the next transaction is taken
// while it waits. If the receiver still stalls a previous result when a new
// one is ready, the sequencer holds on its last pass until the register frees.
// Reset puts every accumulator at a quarter turn and the gain at zero.
// Gain is written through the apb-style port at byte address 0 by the user,
// only while idle; the block itself does not enforce this.
`default_nettype none

module ring_modulator_nco #(
  parameter int TRACKS          = rmn_pkg::TRACKS_DEF,
  parameter int SINE_TABLE_BITS = rmn_pkg::SINE_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire rmn_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output rmn_pkg::out_t     out_data_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int FBITS  = SINE_TABLE_BITS - 2;
  localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  // control
  rmn_pkg::state_e state_q;
  rmn_pkg::step_e  step_q;
  rmn_pkg::step_e  step_nxt;
  logic            out_valid_q;
  logic            accept;
  logic            out_free;
  logic            finish;

  // phase store
  logic [31:0]          phase_q [TRACKS];
  logic [TIDX_W-1:0]    tidx;
  logic                 in_range;
  logic [31:0]          phase_rd;
  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [16:0]          u_frac;
  logic [16:0]          u_acc;

  // datapath registers
  logic [2:0]           track_q;
  logic signed [23:0]   sample_q;
  logic                 pass_q;
  logic                 neg_q;
  logic [16:0]          u_q;
  logic [16:0]          u2_q;
  logic signed [31:0]   op_a_q;
  logic signed [31:0]   op_b_q;
  rmn_pkg::out_t        out_q;

  // shared unit and its derived values
  rmn_pkg::mul_req_t    mul_req;
  logic signed [63:0]   prod;
  logic signed [63:0]   prod_rnd;
  logic [16:0]          rnd17;
  logic [16:0]          inner_v;
  logic [16:0]          mid_v;
  logic [16:0]          mag_v;
  logic signed [17:0]   sine_v;
  logic [16:0]          gain;
  logic [31:0]          dry_v;
  logic signed [31:0]   factor_v;
  logic signed [63:0]   res_v;
  logic signed [23:0]   sat_v;

  rmn_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gain_o  (gain)
  );

  assign mul_req.en = (state_q == rmn_pkg::ST_MUL);
  assign mul_req.a  = op_a_q;
  assign mul_req.b  = op_b_q;

  rmn_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // handshake
  assign in_stall_o  = (state_q != rmn_pkg::ST_IDLE);
  assign accept      = in_valid_i && (state_q == rmn_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish      = (state_q == rmn_pkg::ST_NEXT) && (step_q == rmn_pkg::STEP_SF)
                       && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // phase lookup and sine argument
  assign tidx     = TIDX_W'(in_data_i.track);
  assign in_range = (32'(in_data_i.track) < 32'(TRACKS));
  assign phase_rd = phase_q[tidx];
  assign sidx     = phase_rd[31 -: SINE_TABLE_BITS];
  assign u_frac   = 17'(sidx[FBITS-1:0]) << (15 - FBITS);
  assign u_acc    = sidx[FBITS] ? (rmn_pkg::Q15_ONE - u_frac) : u_frac;

  // accumulators advance at accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TRACKS; i++) begin
        phase_q[i] <= rmn_pkg::PHASE_RESET;
      end
    end else if (accept && in_range) begin
      phase_q[tidx] <= phase_rd + in_data_i.phase_step;
    end
  end

  // values formed from the last product
  always_comb begin
    prod_rnd = (prod + 64'sd16384) >>> 15;
    rnd17    = prod_rnd[16:0];
    inner_v  = rmn_pkg::COEF_B - rnd17;
    mid_v    = rmn_pkg::COEF_A - rnd17;
    mag_v    = (rnd17 > rmn_pkg::Q15_ONE) ? rmn_pkg::Q15_ONE : rnd17;
    sine_v   = neg_q ? -signed'({1'b0, mag_v}) : signed'({1'b0, mag_v});
    dry_v    = 32'(rmn_pkg::Q15_ONE - gain) << 15;
    factor_v = signed'(dry_v) + prod[31:0];
    res_v    = (prod + 64'sd536870912) >>> 30;
    sat_v    = (res_v > rmn_pkg::SAMPLE_MAX) ? 24'sd8388607 : res_v[23:0];
  end

  // next multiplier pass
  always_comb begin
    step_nxt = rmn_pkg::step_e'(step_q + 3'd1);
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmn_pkg::ST_IDLE;
      step_q      <= rmn_pkg::STEP_SQ;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        rmn_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= rmn_pkg::ST_MUL;
            step_q  <= rmn_pkg::STEP_SQ;
          end
        end
        rmn_pkg::ST_MUL: begin
          state_q <= rmn_pkg::ST_NEXT;
        end
        rmn_pkg::ST_NEXT: begin
          if (step_q == rmn_pkg::STEP_SF) begin
            if (out_free) begin
              state_q <= rmn_pkg::ST_IDLE;
            end
          end else begin
            state_q <= rmn_pkg::ST_MUL;
            step_q  <= step_nxt;
          end
        end
        default: begin
          state_q <= rmn_pkg::ST_IDLE;
        end
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers and operand loading
  always_ff @(posedge clk_i) begin
    if (accept) begin
      track_q  <= in_data_i.track;
      sample_q <= in_data_i.sample;
      pass_q   <= !in_range;
      neg_q    <= sidx[SINE_TABLE_BITS-1];
      u_q      <= u_acc;
      op_a_q   <= signed'(32'(u_acc));
      op_b_q   <= signed'(32'(u_acc));
    end else if (state_q == rmn_pkg::ST_NEXT) begin
      unique case (step_q)
        rmn_pkg::STEP_SQ: begin
          u2_q   <= rnd17;
          op_a_q <= signed'(32'(rmn_pkg::COEF_C));
          op_b_q <= signed'(32'(rnd17));
        end
        rmn_pkg::STEP_C: begin
          op_a_q <= signed'(32'(inner_v));
          op_b_q <= signed'(32'(u2_q));
        end
        rmn_pkg::STEP_IN: begin
          op_a_q <= signed'(32'(mid_v));
          op_b_q <= signed'(32'(u_q));
        end
        rmn_pkg::STEP_MID: begin
          op_a_q <= signed'(32'(gain));
          op_b_q <= 32'(sine_v);
        end
        rmn_pkg::STEP_GS: begin
          op_a_q <= 32'(sample_q);
          op_b_q <= factor_v;
        end
        rmn_pkg::STEP_SF: begin
          if (out_free) begin
            out_q.out_track  <= track_q;
            out_q.out_sample <= pass_q ? sample_q : sat_v;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a multiply cycle always follows an accepted transaction
  a_accept_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == rmn_pkg::ST_MUL) && (step_q == rmn_pkg::STEP_SQ))
    else $error("accepted transaction did not start the first multiply");

  // each multiply cycle is followed by its result step
  a_mul_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rmn_pkg::ST_MUL) |=> (state_q == rmn_pkg::ST_NEXT) && $stable(step_q))
    else $error("multiply cycle not followed by its result step");

  // a new result only comes from the last pass
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(finish))
    else $error("output appeared without a finished transaction");

  // state register stays one-hot
  a_state_oh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  // a result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !finish)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: sv/rmn_mul.sv
// rmn_mul: shared signed 32x32 multiplier with registered product
// uses rmn_pkg for the request struct
`default_nettype none

module rmn_mul (
  input  wire logic              clk_i,
  input  wire rmn_pkg::mul_req_t req_i,
  output logic signed [63:0]     prod_o
);

  logic signed [63:0] prod_d;
  logic signed [63:0] prod_q;

  // one product per enabled cycle
  assign prod_d = req_i.a * req_i.b;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: sv/rmn_apb.sv
// rmn_apb: apb-style configuration port holding the modulation gain
// uses rmn_pkg for the register index
`default_nettype none

module rmn_apb (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [16:0]      gain_o
);

  logic [15:0] mod_gain_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == rmn_pkg::REG_MOD_GAIN);

  // gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_gain_q <= '0;
    end else if (wr_en) begin
      mod_gain_q <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr == rmn_pkg::REG_MOD_GAIN) begin
      prdata = {16'd0, mod_gain_q};
    end
  end

  // gain above unity saturates to unity
  assign gain_o = ({1'b0, mod_gain_q} > rmn_pkg::Q15_ONE) ? rmn_pkg::Q15_ONE
                                                            : {1'b0, mod_gain_q};

endmodule

`default_nettype wire

// File: bench/ring_modulator_nco_test.sv
// ring_modulator_nco_test: self-checking bench for the ring modulator with
// per-track phase accumulators; needs rmn_pkg and the ring_modulator_nco rtl
`timescale 1ns / 100ps

module ring_modulator_nco_test;

  localparam int     NUM_TRACKS   = rmn_pkg::TRACKS_DEF;
  localparam int     SINE_BITS    = rmn_pkg::SINE_BITS_DEF;
  localparam int     FRAC_BITS    = SINE_BITS - 2;
  localparam longint UNITY        = longint'(rmn_pkg::Q15_ONE);
  localparam longint POLY_A       = longint'(rmn_pkg::COEF_A);
  localparam longint POLY_B       = longint'(rmn_pkg::COEF_B);
  localparam longint POLY_C       = longint'(rmn_pkg::COEF_C);
  localparam int     PHASES       = 8;
  localparam int     PHASE_ITEMS  = 119;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     CYCLE_LIMIT  = 250000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic           in_valid = 1'b0;
  logic           in_stall_o;
  rmn_pkg::in_t   in_data  = '0;
  logic           out_valid_o;
  logic           out_stall = 1'b0;
  rmn_pkg::out_t  out_data_o;
  logic           psel     = 1'b0;
  logic           penable  = 1'b0;
  logic           pwrite   = 1'b0;
  logic [1:0]     paddr    = '0;
  logic [31:0]    pwdata   = '0;
  logic [31:0]    prdata;
  logic           pready;

  // predictor state: accumulators and gain as the block should hold them
  logic [31:0]    acc_phase [NUM_TRACKS];
  logic [15:0]    depth_gain;

  rmn_pkg::in_t   stim_q[$];
  rmn_pkg::out_t  modulated_q[$];

  int             mismatches  = 0;
  int             cycle_cnt   = 0;
  int             in_gap      = 0;
  int             out_gap     = 0;
  logic           in_idle_en  = 1'b1;
  logic           out_idle_en = 1'b1;

  ring_modulator_nco dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // q15 product, rounded half up
  function automatic longint q15_round_mul(longint x, longint y);
    return (x * y + 16384) >>> 15;
  endfunction

  // polynomial sine of the truncated phase, q15 in [-1, 1]
  function automatic longint poly_sine(logic [31:0] ph);
    int     idx;
    int     quad;
    longint u;
    longint u2;
    longint inner;
    longint mid;
    longint mag;
    idx  = int'(ph >> (32 - SINE_BITS));
    quad = (idx >> FRAC_BITS) & 3;
    u    = longint'(idx & ((1 << FRAC_BITS) - 1)) << (15 - FRAC_BITS);
    if (quad[0]) begin
      u = UNITY - u;
    end
    u2    = q15_round_mul(u, u);
    inner = POLY_B - q15_round_mul(POLY_C, u2);
    mid   = POLY_A - q15_round_mul(inner, u2);
    mag   = q15_round_mul(mid, u);
    if (mag > UNITY) begin
      mag = UNITY;
    end
    return quad[1] ? -mag : mag;
  endfunction

  // expected output of one transaction; advances the track's accumulator
  function automatic rmn_pkg::out_t modulate(rmn_pkg::in_t item);
    longint        g;
    longint        factor;
    longint        prod;
    longint        res;
    rmn_pkg::out_t o;
    g      = (depth_gain > 16'd32768) ? UNITY : longint'(depth_gain);
    factor = (UNITY - g) * UNITY + g * poly_sine(acc_phase[item.track]);
    prod   = longint'($signed(item.sample)) * factor + (64'sd1 <<< 29);
    res    = prod >>> 30;
    if (res > 64'sd8388607) begin
      res = 64'sd8388607;
    end
    if (res < -64'sd8388608) begin
      res = -64'sd8388608;
    end
    acc_phase[item.track] = acc_phase[item.track] + item.phase_step;
    o.out_track  = item.track;
    o.out_sample = res[23:0];
    return o;
  endfunction

  // input driver: predicts on accept, then picks a gap or the next item
  always @(posedge clk_i) begin
    if (in_valid && !in_stall_o) begin
      modulated_q.push_back(modulate(in_data));
    end
    if (!in_valid || !in_stall_o) begin
      if (in_gap != 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (in_idle_en && $urandom_range(0, 5) == 0) begin
        in_gap   <= $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        in_data  <= stim_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor: compares each accepted transaction with the oldest prediction
  always @(posedge clk_i) begin
    rmn_pkg::out_t want;
    if (out_valid_o && !out_stall) begin
      if (modulated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected output transaction, track %0d sample %0d", $time,
                   out_data_o.out_track, $signed(out_data_o.out_sample));
        end
      end else begin
        want = modulated_q.pop_front();
        if (out_data_o.out_track !== want.out_track ||
            out_data_o.out_sample !== want.out_sample) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: output mismatch, got track %0d sample %0d, want track %0d sample %0d",
                     $time, out_data_o.out_track, $signed(out_data_o.out_sample),
                     want.out_track, $signed(want.out_sample));
          end
        end
      end
    end
    // receiver stall bursts
    if (!out_idle_en) begin
      out_gap   <= 0;
      out_stall <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap   <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_gap   <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // apb write: setup cycle, then access until pready
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rmn_pkg::REG_MOD_GAIN) begin
      depth_gain = value[15:0];
    end
  endtask

  task automatic push(logic [2:0] trk, logic [23:0] smp, logic [31:0] stp);
    rmn_pkg::in_t item;
    item.track      = trk;
    item.sample     = smp;
    item.phase_step = stp;
    stim_q.push_back(item);
  endtask

  // hold the sender until every prediction has been matched, then settle;
  // checked mid-cycle so the driver's updates of the same edge are seen
  task automatic drain();
    do @(negedge clk_i); while (stim_q.size() != 0 || in_valid || modulated_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    rmn_pkg::in_t item;
    logic [31:0]  r;
    logic [15:0]  gains [PHASES];
    foreach (acc_phase[i]) begin
      acc_phase[i] = rmn_pkg::PHASE_RESET;
    end
    depth_gain = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero gain: samples pass, accumulators still move
    write_reg(rmn_pkg::REG_MOD_GAIN, 32'd0);
    push(3'd0, 24'h7FFFFF, 32'h7FFF_FFFF);
    push(3'd1, 24'h800000, 32'h8000_0000);
    push(3'd2, 24'hFFFFFF, 32'hFFFF_FFFF);
    push(3'd3, 24'h000001, 32'h0000_0001);
    push(3'd7, 24'h000000, 32'h4000_0000);
    drain();

    // full depth: sine extremes, full negative product saturates
    write_reg(rmn_pkg::REG_MOD_GAIN, 32'd32768);
    push(3'd1, 24'h800000, 32'h0);
    push(3'd1, 24'h7FFFFF, 32'h0);
    push(3'd0, 24'h7FFFFF, 32'h0);
    push(3'd4, 24'h800000, 32'h2000_0000);
    push(3'd4, 24'h7FFFFF, 32'h2000_0000);
    push(3'd5, 24'd12345, 32'h7FFF_FFFF);
    push(3'd6, -24'sd4321, 32'h8000_0000);
    push(3'd7, 24'h7FFFFF, 32'h0);
    push(3'd2, 24'h7FFFFF, 32'h0);
    push(3'd3, 24'h800000, 32'h0);
    drain();

    // gain above one behaves as full depth
    write_reg(rmn_pkg::REG_MOD_GAIN, 32'h0000_FFFF);
    push(3'd0, 24'h800000, 32'h1234_5678);
    push(3'd5, 24'h7FFFFF, 32'h0);
    push(3'd6, 24'h000001, 32'hFFFF_FFFF);
    push(3'd1, 24'hFFFFFF, 32'h0);
    drain();

    write_reg(rmn_pkg::REG_MOD_GAIN, 32'd16384);
    push(3'd2, 24'h7FFFFF, 32'h0);
    push(3'd3, 24'h800000, 32'h0);
    drain();

    // random phases over a spread of gains; the last one runs without idling
    gains[0] = 16'd32768;
    gains[1] = 16'd0;
    gains[2] = 16'($urandom_range(0, 32768));
    gains[3] = 16'd1;
    gains[4] = 16'hFFFF;
    gains[5] = 16'd32767;
    gains[6] = 16'($urandom);
    gains[7] = 16'($urandom_range(0, 32768));
    for (int p = 0; p < PHASES; p++) begin
      in_idle_en  = (p != PHASES - 1) && (p != 4);
      out_idle_en = (p != PHASES - 1) && (p != 2);
      write_reg(rmn_pkg::REG_MOD_GAIN, {16'd0, gains[p]});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        item.track = 3'($urandom_range(0, NUM_TRACKS - 1));
        case ($urandom_range(0, 7))
          0:       item.sample = 24'h7FFFFF;
          1:       item.sample = 24'h800000;
          2:       item.sample = 24'h000000;
          3:       item.sample = 24'hFFFFFF;
          default: item.sample = 24'($urandom);
        endcase
        r = $urandom;
        case ($urandom_range(0, 3))
          0:       item.phase_step = {{12{r[19]}}, r[19:0]};
          1:       item.phase_step = {2'($urandom_range(0, 3)), 30'd0};
          default: item.phase_step = r;
        endcase
        stim_q.push_back(item);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
